// ----- rtl/assert_macros.svh -----
// assertion macros shared by the fluid grid rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ----- rtl/mfgs_pkg.sv -----
// types, codes and constants of the fluid grid block
// used by mfgs_ctrl, mfgs_dp and mass_fluid_grid_step
package mfgs_pkg;

  localparam int GRID_COLS_DEF = 128;
  localparam int GRID_ROWS_DEF = 64;

  localparam int MASS_W = 24;
  localparam int KIND_W = 2;
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] DRY_LIMIT_RST = 16'd7;
  localparam logic [MASS_W-1:0] MASS_MAX = 24'hFFFFFF;

  // stable split constants, q8.16
  localparam int ONE_Q16 = 65536;
  localparam int SPLIT_MID = 147456;
  localparam int SPLIT_HI_BIAS = 16384;
  // divide by five through a reciprocal
  localparam int DIV5_X_W = 19;
  localparam int DIV5_MUL_W = 20;
  localparam int DIV5_MUL = 838861;
  localparam int DIV5_SHIFT = 22;
  localparam int PROD_W = DIV5_X_W + DIV5_MUL_W;
  localparam int QUOT_W = PROD_W - DIV5_SHIFT;

  localparam logic [1:0] ACT_EDIT = 2'd0;
  localparam logic [1:0] ACT_GEN = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WATER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] col;
    logic [5:0] row;
    logic [1:0] cell_kind;
    logic [23:0] mass_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind_out;
    logic [23:0] mass_out;
  } rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MASS_W-1:0] mass;
  } cell_t;

  typedef enum logic [2:0] {
    TGT_CMD = 3'd0,
    TGT_SELF = 3'd1,
    TGT_BELOW = 3'd2,
    TGT_LEFT = 3'd3,
    TGT_RIGHT = 3'd4
  } tgt_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_INIT = 2'd1,
    OP_EDIT = 2'd2,
    OP_POUR = 2'd3
  } wr_op_t;

  typedef struct packed {
    logic rd;
    logic wr;
    tgt_t tgt;
    logic nxt;
    wr_op_t op;
    logic ld_cmd;
    logic scan_rst;
    logic scan_inc;
    logic ld_self;
    logic ld_sum;
    logic ld_prod;
    logic ld_down;
    logic ld_side;
    logic ld_keep;
    logic flip;
    logic ld_rsp;
  } dp_ctl_t;

  typedef struct packed {
    logic scan_last;
    logic at_left;
    logic at_right;
    logic at_bottom;
    logic self_active;
    logic nb_wall;
    logic rem_keep;
    logic edit_ok;
  } dp_sts_t;

endpackage

// ----- rtl/mfgs_dp.sv -----
// grid memory, scan counters and flow arithmetic of the fluid grid
// depends on mfgs_pkg and assert_macros.svh
`include "assert_macros.svh"

module mfgs_dp #(
  parameter int GRID_COLS = mfgs_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = mfgs_pkg::GRID_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mfgs_pkg::cmd_t    cmd,
  input  logic              cfg_wr,
  input  logic [15:0]       cfg_data,
  input  mfgs_pkg::dp_ctl_t ctl,
  output mfgs_pkg::dp_sts_t sts,
  output mfgs_pkg::rsp_t    rsp
);
  import mfgs_pkg::*;

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int MEM_DEPTH = 2 << IDX_W;

  cell_t grid [MEM_DEPTH];
  cell_t rdata;
  cell_t wdata;

  cmd_t cmd_q;
  logic [CFG_W-1:0] dry_limit;
  logic cur_bank;
  logic [IDX_W-1:0] scan_idx;
  logic [CW-1:0] scan_col;
  logic [RW-1:0] scan_row;

  logic [MASS_W-1:0] rem;
  logic [MASS_W-1:0] below_m;
  logic [MASS_W:0] t_sum;
  logic [QUOT_W-1:0] quot;
  logic [MASS_W-1:0] flow;
  rsp_t rsp_q;

  logic in_grid;
  logic [31:0] cmd_lin;
  logic [IDX_W-1:0] cmd_idx;
  logic [IDX_W-1:0] tgt_idx;
  logic [IDX_W:0] addr;
  logic [PROD_W-1:0] prod;
  logic [MASS_W+1:0] hi_sum;
  logic [MASS_W:0] stable;
  logic [MASS_W+1:0] down_diff;
  logic [MASS_W-1:0] down_flow;
  logic [MASS_W:0] side_diff;
  logic [MASS_W-1:0] side_flow;
  logic [MASS_W:0] pour_sum;
  logic pour_wr;

  assign in_grid = (32'(cmd_q.col) < 32'(GRID_COLS)) && (32'(cmd_q.row) < 32'(GRID_ROWS));
  assign cmd_lin = 32'(cmd_q.row) * 32'(GRID_COLS) + 32'(cmd_q.col);
  assign cmd_idx = in_grid ? cmd_lin[IDX_W-1:0] : '0;

  always_comb begin
    case (ctl.tgt)
      TGT_CMD: tgt_idx = cmd_idx;
      TGT_SELF: tgt_idx = scan_idx;
      TGT_BELOW: tgt_idx = scan_idx + IDX_W'(GRID_COLS);
      TGT_LEFT: tgt_idx = scan_idx - 1'b1;
      TGT_RIGHT: tgt_idx = scan_idx + 1'b1;
      default: tgt_idx = scan_idx;
    endcase
  end

  assign addr = {ctl.nxt ? ~cur_bank : cur_bank, tgt_idx};

  // flow arithmetic
  assign prod = PROD_W'({1'b1, t_sum[DIV5_X_W-2:0]}) * PROD_W'(DIV5_MUL);
  assign hi_sum = {1'b0, t_sum} + (MASS_W+2)'(SPLIT_HI_BIAS);

  always_comb begin
    if (t_sum <= (MASS_W+1)'(ONE_Q16)) begin
      stable = (MASS_W+1)'(ONE_Q16);
    end else if (t_sum < (MASS_W+1)'(SPLIT_MID)) begin
      stable = (MASS_W+1)'(quot);
    end else begin
      stable = hi_sum[MASS_W+1:1];
    end
  end

  assign down_diff = {1'b0, stable} - {2'b00, below_m};

  always_comb begin
    if (down_diff[MASS_W+1]) begin
      down_flow = '0;
    end else if (down_diff[MASS_W:0] > {1'b0, rem}) begin
      down_flow = rem;
    end else begin
      down_flow = down_diff[MASS_W-1:0];
    end
  end

  assign side_diff = {1'b0, rem} - {1'b0, rdata.mass};
  assign side_flow = side_diff[MASS_W] ? '0 : {2'b00, side_diff[MASS_W-1:2]};

  assign pour_sum = {1'b0, rdata.mass} + {1'b0, flow};
  assign pour_wr = ctl.wr && (ctl.op == OP_POUR);

  always_comb begin
    case (ctl.op)
      OP_CLEAR: wdata = '{kind: KIND_EMPTY, mass: '0};
      OP_INIT: wdata = '{kind: (rdata.kind == KIND_WALL) ? KIND_WALL : KIND_EMPTY, mass: '0};
      OP_EDIT: begin
        if (cmd_q.cell_kind == KIND_WATER) begin
          wdata = '{kind: KIND_WATER, mass: cmd_q.mass_in};
        end else begin
          wdata = '{kind: cmd_q.cell_kind, mass: '0};
        end
      end
      OP_POUR: wdata = '{kind: KIND_WATER,
                         mass: pour_sum[MASS_W] ? MASS_MAX : pour_sum[MASS_W-1:0]};
      default: wdata = '{kind: KIND_EMPTY, mass: '0};
    endcase
  end

  // grid store, current and next banks
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      grid[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= grid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_limit <= DRY_LIMIT_RST;
      cur_bank <= 1'b0;
      scan_idx <= '0;
      scan_col <= '0;
      scan_row <= '0;
    end else begin
      if (cfg_wr) begin
        dry_limit <= cfg_data;
      end
      if (ctl.flip) begin
        cur_bank <= ~cur_bank;
      end
      if (ctl.scan_rst) begin
        scan_idx <= '0;
        scan_col <= '0;
        scan_row <= '0;
      end else if (ctl.scan_inc) begin
        scan_idx <= scan_idx + 1'b1;
        if (sts.at_right) begin
          scan_col <= '0;
          scan_row <= scan_row + 1'b1;
        end else begin
          scan_col <= scan_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_cmd) begin
      cmd_q <= cmd;
    end
    if (ctl.ld_self) begin
      rem <= rdata.mass;
    end else if (pour_wr) begin
      rem <= rem - flow;
    end
    if (ctl.ld_sum) begin
      below_m <= rdata.mass;
      t_sum <= {1'b0, rem} + {1'b0, rdata.mass};
    end
    if (ctl.ld_prod) begin
      quot <= prod[PROD_W-1:DIV5_SHIFT];
    end
    if (ctl.ld_down) begin
      flow <= down_flow;
    end else if (ctl.ld_side) begin
      flow <= side_flow;
    end else if (ctl.ld_keep) begin
      flow <= rem;
    end
    if (ctl.ld_rsp) begin
      rsp_q <= in_grid ? rsp_t'{kind_out: rdata.kind, mass_out: rdata.mass} : '0;
    end
  end

  assign rsp = rsp_q;

  assign sts.scan_last = (scan_idx == IDX_W'(CELLS - 1));
  assign sts.at_left = (scan_col == '0);
  assign sts.at_right = (scan_col == CW'(GRID_COLS - 1));
  assign sts.at_bottom = (scan_row == RW'(GRID_ROWS - 1));
  assign sts.self_active = (rdata.kind == KIND_WATER) && (rdata.mass > MASS_W'(dry_limit));
  assign sts.nb_wall = (rdata.kind == KIND_WALL);
  assign sts.rem_keep = (rem > MASS_W'(dry_limit));
  assign sts.edit_ok = in_grid && ((cmd_q.cell_kind == KIND_EMPTY)
                                   || (cmd_q.cell_kind == KIND_WALL)
                                   || ((cmd_q.cell_kind == KIND_WATER)
                                       && (rdata.kind != KIND_WALL)));

  `ASSERT_IMPLY(a_flow_le_rem, clk, rst, pour_wr && (ctl.tgt != TGT_SELF), flow <= rem, "flow exceeds remaining mass")
  `ASSERT_IMPLY(a_bank_flip, clk, rst, cur_bank != $past(cur_bank), $past(ctl.flip), "bank changed without flip")
  `ASSERT_IMPLY(a_scan_bound, clk, rst, ctl.scan_inc, !sts.scan_last, "scan stepped past last cell")

endmodule

// ----- rtl/mfgs_ctrl.sv -----
// sequencer of the fluid grid: command handling and generation sweep
// depends on mfgs_pkg and assert_macros.svh
`include "assert_macros.svh"

module mfgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [1:0]        cmd_action,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output mfgs_pkg::dp_ctl_t ctl,
  input  mfgs_pkg::dp_sts_t sts
);
  import mfgs_pkg::*;

  typedef enum logic [21:0] {
    S_CLR        = 22'h000001,
    S_IDLE       = 22'h000002,
    S_EDIT_RD    = 22'h000004,
    S_EDIT_WR    = 22'h000008,
    S_READ_RD    = 22'h000010,
    S_READ_OUT   = 22'h000020,
    S_INIT_RD    = 22'h000040,
    S_INIT_WR    = 22'h000080,
    S_SELF_RD    = 22'h000100,
    S_SELF_CHK   = 22'h000200,
    S_BELOW_CHK  = 22'h000400,
    S_MUL        = 22'h000800,
    S_FLOW       = 22'h001000,
    S_POUR_DOWN  = 22'h002000,
    S_LEFT_RD    = 22'h004000,
    S_LEFT_CHK   = 22'h008000,
    S_POUR_LEFT  = 22'h010000,
    S_RIGHT_RD   = 22'h020000,
    S_RIGHT_CHK  = 22'h040000,
    S_POUR_RIGHT = 22'h080000,
    S_KEEP       = 22'h100000,
    S_POUR_SELF  = 22'h200000
  } state_t;

  state_t state;
  state_t state_next;
  logic cmd_acc;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc = cmd_valid && !cmd_stall;

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        ctl.wr = 1'b1;
        ctl.tgt = TGT_SELF;
        ctl.op = OP_CLEAR;
        if (sts.scan_last) begin
          ctl.scan_rst = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_IDLE: begin
        ctl.ld_cmd = cmd_acc;
        if (cmd_acc) begin
          case (cmd_action)
            ACT_EDIT: state_next = S_EDIT_RD;
            ACT_GEN: begin
              ctl.scan_rst = 1'b1;
              state_next = S_INIT_RD;
            end
            ACT_READ: state_next = S_READ_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EDIT_RD: begin
        ctl.rd = 1'b1;
        ctl.tgt = TGT_CMD;
        state_next = S_EDIT_WR;
      end
      S_EDIT_WR: begin
        ctl.wr = sts.edit_ok;
        ctl.tgt = TGT_CMD;
        ctl.op = OP_EDIT;
        state_next = S_IDLE;
      end
      S_READ_RD: begin
        ctl.rd = 1'b1;
        ctl.tgt = TGT_CMD;
        state_next = S_READ_OUT;
      end
      S_READ_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          ctl.ld_rsp = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INIT_RD: begin
        ctl.rd = 1'b1;
        ctl.tgt = TGT_SELF;
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        ctl.wr = 1'b1;
        ctl.tgt = TGT_SELF;
        ctl.nxt = 1'b1;
        ctl.op = OP_INIT;
        if (sts.scan_last) begin
          ctl.scan_rst = 1'b1;
          state_next = S_SELF_RD;
        end else begin
          ctl.scan_inc = 1'b1;
          state_next = S_INIT_RD;
        end
      end
      S_SELF_RD: begin
        ctl.rd = 1'b1;
        ctl.tgt = TGT_SELF;
        state_next = S_SELF_CHK;
      end
      S_SELF_CHK: begin
        ctl.ld_self = 1'b1;
        if (!sts.self_active) begin
          if (sts.scan_last) begin
            ctl.flip = 1'b1;
            state_next = S_IDLE;
          end else begin
            ctl.scan_inc = 1'b1;
            state_next = S_SELF_RD;
          end
        end else if (!sts.at_bottom) begin
          ctl.rd = 1'b1;
          ctl.tgt = TGT_BELOW;
          state_next = S_BELOW_CHK;
        end else begin
          state_next = S_LEFT_RD;
        end
      end
      S_BELOW_CHK: begin
        if (sts.nb_wall) begin
          state_next = S_LEFT_RD;
        end else begin
          ctl.ld_sum = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ctl.ld_prod = 1'b1;
        state_next = S_FLOW;
      end
      S_FLOW: begin
        ctl.ld_down = 1'b1;
        ctl.rd = 1'b1;
        ctl.tgt = TGT_BELOW;
        ctl.nxt = 1'b1;
        state_next = S_POUR_DOWN;
      end
      S_POUR_DOWN: begin
        ctl.wr = 1'b1;
        ctl.tgt = TGT_BELOW;
        ctl.nxt = 1'b1;
        ctl.op = OP_POUR;
        state_next = S_LEFT_RD;
      end
      S_LEFT_RD: begin
        if (sts.at_left) begin
          state_next = S_RIGHT_RD;
        end else begin
          ctl.rd = 1'b1;
          ctl.tgt = TGT_LEFT;
          state_next = S_LEFT_CHK;
        end
      end
      S_LEFT_CHK: begin
        if (sts.nb_wall) begin
          state_next = S_RIGHT_RD;
        end else begin
          ctl.ld_side = 1'b1;
          ctl.rd = 1'b1;
          ctl.tgt = TGT_LEFT;
          ctl.nxt = 1'b1;
          state_next = S_POUR_LEFT;
        end
      end
      S_POUR_LEFT: begin
        ctl.wr = 1'b1;
        ctl.tgt = TGT_LEFT;
        ctl.nxt = 1'b1;
        ctl.op = OP_POUR;
        state_next = S_RIGHT_RD;
      end
      S_RIGHT_RD: begin
        if (sts.at_right) begin
          state_next = S_KEEP;
        end else begin
          ctl.rd = 1'b1;
          ctl.tgt = TGT_RIGHT;
          state_next = S_RIGHT_CHK;
        end
      end
      S_RIGHT_CHK: begin
        if (sts.nb_wall) begin
          state_next = S_KEEP;
        end else begin
          ctl.ld_side = 1'b1;
          ctl.rd = 1'b1;
          ctl.tgt = TGT_RIGHT;
          ctl.nxt = 1'b1;
          state_next = S_POUR_RIGHT;
        end
      end
      S_POUR_RIGHT: begin
        ctl.wr = 1'b1;
        ctl.tgt = TGT_RIGHT;
        ctl.nxt = 1'b1;
        ctl.op = OP_POUR;
        state_next = S_KEEP;
      end
      S_KEEP: begin
        if (sts.rem_keep) begin
          ctl.ld_keep = 1'b1;
          ctl.rd = 1'b1;
          ctl.tgt = TGT_SELF;
          ctl.nxt = 1'b1;
          state_next = S_POUR_SELF;
        end else if (sts.scan_last) begin
          ctl.flip = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.scan_inc = 1'b1;
          state_next = S_SELF_RD;
        end
      end
      S_POUR_SELF: begin
        ctl.wr = 1'b1;
        ctl.tgt = TGT_SELF;
        ctl.nxt = 1'b1;
        ctl.op = OP_POUR;
        if (sts.scan_last) begin
          ctl.flip = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.scan_inc = 1'b1;
          state_next = S_SELF_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.ld_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_gen_start, clk, rst, cmd_acc && (cmd_action == ACT_GEN), state == S_INIT_RD, "generation did not begin with init sweep")
  `ASSERT_IMPLY(a_rsp_slot, clk, rst, ctl.ld_rsp, !rsp_valid || !rsp_stall, "pending response overwritten")
  `ASSERT_IMPLY(a_pour_next, clk, rst, ctl.wr && (ctl.op == OP_POUR), ctl.nxt, "pour aimed at current grid")

endmodule

// ----- rtl/mass_fluid_grid_step.sv -----
// top level of the mass based fluid grid
// depends on mfgs_pkg, mfgs_ctrl and mfgs_dp
//
// One command transfer at a time: edit reads the cell and writes it if the
// edit is allowed, read reads it and waits for a free response slot, both
// through one single port grid memory holding the current and next banks.
// A generation first seeds the next bank from the current one, cell by cell,
// then steps through the cells again: a dry cell is only read, a flowing
// cell may pour into the cells below, left and right and keep its rest in
// the next bank. After reset a clearing pass of one cell per cycle runs
// before the first command is taken; dry limit writes are taken at any time.

module mass_fluid_grid_step #(
  parameter int GRID_COLS = mfgs_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = mfgs_pkg::GRID_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  mfgs_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mfgs_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);
  import mfgs_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mfgs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_action (cmd.action),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .ctl        (ctl),
    .sts        (sts)
  );

  mfgs_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule
